FILE: rtl/core/cie94_pkg.sv
// ----------------------------------------------------------------------------
// cie94_pkg
// Shared constants and types of the CIE94 color difference core.
// ----------------------------------------------------------------------------
package cie94_pkg;

	localparam int LIGHT_W = 15;
	localparam int AXIS_W  = 16;
	localparam int DIFF_W  = 17;

	// guard bits carried through the weighted terms
	localparam int GUARD_BITS   = 8;
	// weight constants are unsigned Q16
	localparam int K_SCALE_BITS = 16;
	localparam int K_W          = 12;

	localparam logic [K_W-1:0] K1_GRAPHIC = 12'd2949;
	localparam logic [K_W-1:0] K2_GRAPHIC = 12'd983;
	localparam logic [K_W-1:0] K1_TEXTILE = 12'd3146;
	localparam logic [K_W-1:0] K2_TEXTILE = 12'd918;

	localparam logic [DIFF_W-1:0] DIFF_MAX = 17'h1FFFF;

	typedef enum logic {
		WEIGHTS_GRAPHIC = 1'b0,
		WEIGHTS_TEXTILE = 1'b1
	} weights_t;

endpackage

FILE: rtl/core/cie94_in_if.sv
// ----------------------------------------------------------------------------
// cie94_in_if
// Color pair channel: valid/ready with both Lab colors as payload.
// ----------------------------------------------------------------------------
interface cie94_in_if;
	logic                                valid;
	logic                                ready;
	logic [cie94_pkg::LIGHT_W-1:0]       light_first;
	logic signed [cie94_pkg::AXIS_W-1:0] green_red_first;
	logic signed [cie94_pkg::AXIS_W-1:0] blue_yellow_first;
	logic [cie94_pkg::LIGHT_W-1:0]       light_second;
	logic signed [cie94_pkg::AXIS_W-1:0] green_red_second;
	logic signed [cie94_pkg::AXIS_W-1:0] blue_yellow_second;

	modport source (
		output valid, light_first, green_red_first, blue_yellow_first,
		output light_second, green_red_second, blue_yellow_second,
		input  ready
	);
	modport sink (
		input  valid, light_first, green_red_first, blue_yellow_first,
		input  light_second, green_red_second, blue_yellow_second,
		output ready
	);
endinterface

FILE: rtl/core/cie94_out_if.sv
// ----------------------------------------------------------------------------
// cie94_out_if
// Result channel: valid/ready with the delta E and its clip flag.
// ----------------------------------------------------------------------------
interface cie94_out_if;
	logic                          valid;
	logic                          ready;
	logic [cie94_pkg::DIFF_W-1:0]  difference;
	logic                          saturated;

	modport source (output valid, difference, saturated, input ready);
	modport sink   (input valid, difference, saturated, output ready);
endinterface

FILE: rtl/core/cie94_color_difference_core.sv
// ----------------------------------------------------------------------------
// cie94_color_difference_core
// CIE94 delta E of two Lab colors, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pair of Lab colors per beat (valid/ready); rsp returns
//   one delta E beat per request beat, in order, with a clip flag.
//   cfg_we/cfg_wdata write the weight select (0 graphic arts, 1 textile);
//   write it only while no beat is in flight. Each beat samples it on entry.
// Throughput: one beat per cycle while no result waits in the skid register.
// Pipeline: the capture stage loads at the edge that takes a request beat;
//   the beat then passes the bit-per-cell rows: two 16-cell chroma roots
//   in parallel, a 25-cell hue root, two 25-cell dividers in parallel and
//   a 26-cell final root, plus seven arithmetic stages and the output
//   register.
// Stall: the pipeline advances as a whole. When rsp stalls, one more result
//   lands in a skid register and req.ready drops until the skid drains, so
//   no new pair is taken while a result waits in the skid.
// Reset: clears all valid bits, the skid and the weight select (graphic
//   arts). No clearing pass is needed; there is no stored table.
// ----------------------------------------------------------------------------
module cie94_color_difference_core #(
	parameter int FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	cie94_in_if.sink          req,
	cie94_out_if.source       rsp,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	localparam int F   = FRAC_BITS;
	localparam int G   = cie94_pkg::GUARD_BITS;
	localparam int KS  = cie94_pkg::K_SCALE_BITS;
	// scale denominator width: 2^(F+16) plus a 28-bit weight product
	localparam int SDW = ((F + KS > 28) ? F + KS : 28) + 1;
	localparam int QW  = 25;
	localparam int NW  = F + 41;
	localparam int BSW = 2 * SDW + 32;
	localparam logic [SDW-1:0] ONE = SDW'(1) << (F + KS);

	// weight select register
	cie94_pkg::weights_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cie94_pkg::WEIGHTS_GRAPHIC;
		end else if (cfg_we) begin
			mode_q <= cie94_pkg::weights_t'(cfg_wdata);
		end
	end

	// global advance: hold everything while the skid holds a result
	logic skid_vld_q;
	logic en;

	assign en        = !skid_vld_q;
	assign req.ready = en;

	// ---- stage 1: capture the pair ----
	logic                                vld_s1;
	logic [cie94_pkg::LIGHT_W-1:0]       l1_s1, l2_s1;
	logic signed [cie94_pkg::AXIS_W-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	cie94_pkg::weights_t                 mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l1_s1   <= req.light_first;
			a1_s1   <= req.green_red_first;
			b1_s1   <= req.blue_yellow_first;
			l2_s1   <= req.light_second;
			a2_s1   <= req.green_red_second;
			b2_s1   <= req.blue_yellow_second;
			mode_s1 <= mode_q;
		end
	end

	// ---- stage 2: magnitudes and squares ----
	logic [15:0] ma1, mb1, ma2, mb2, mda, mdb;
	logic [16:0] da, db;
	logic [15:0] dls;
	logic [14:0] mdl;

	always_comb begin
		ma1 = a1_s1[15] ? 16'(-a1_s1) : 16'(a1_s1);
		mb1 = b1_s1[15] ? 16'(-b1_s1) : 16'(b1_s1);
		ma2 = a2_s1[15] ? 16'(-a2_s1) : 16'(a2_s1);
		mb2 = b2_s1[15] ? 16'(-b2_s1) : 16'(b2_s1);
		da  = 17'({a1_s1[15], a1_s1}) - 17'({a2_s1[15], a2_s1});
		db  = 17'({b1_s1[15], b1_s1}) - 17'({b2_s1[15], b2_s1});
		mda = da[16] ? 16'(-da) : da[15:0];
		mdb = db[16] ? 16'(-db) : db[15:0];
		dls = {1'b0, l1_s1} - {1'b0, l2_s1};
		mdl = dls[15] ? 15'(-dls) : dls[14:0];
	end

	logic                vld_s2;
	logic [31:0]         a1q_s2, b1q_s2, a2q_s2, b2q_s2, daq_s2, dbq_s2;
	logic [14:0]         dl_s2;
	cie94_pkg::weights_t mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1q_s2  <= ma1 * ma1;
			b1q_s2  <= mb1 * mb1;
			a2q_s2  <= ma2 * ma2;
			b2q_s2  <= mb2 * mb2;
			daq_s2  <= mda * mda;
			dbq_s2  <= mdb * mdb;
			dl_s2   <= mdl;
			mode_s2 <= mode_s1;
		end
	end

	// ---- stage 3: sums of squares ----
	logic                vld_s3;
	logic [31:0]         r1_s3, r2_s3;
	logic [32:0]         ab2_s3;
	logic [14:0]         dl_s3;
	cie94_pkg::weights_t mode_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s3   <= a1q_s2 + b1q_s2;
			r2_s3   <= a2q_s2 + b2q_s2;
			ab2_s3  <= 33'(daq_s2) + 33'(dbq_s2);
			dl_s3   <= dl_s2;
			mode_s3 <= mode_s2;
		end
	end

	// ---- chroma roots, both colors side by side ----
	logic        c1_vld;
	logic [15:0] c1, c2;
	logic [32:0] ab2_a;
	logic [15:0] side2_a;

	cie94_sqrt_chain #(.RW(16), .SW(33)) u_chroma_first (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.rad_i  (r1_s3),
		.side_i (ab2_s3),
		.vld_o  (c1_vld),
		.root_o (c1),
		.side_o (ab2_a)
	);

	cie94_sqrt_chain #(.RW(16), .SW(16)) u_chroma_second (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.rad_i  (r2_s3),
		.side_i ({mode_s3, dl_s3}),
		.vld_o  (),
		.root_o (c2),
		.side_o (side2_a)
	);

	// ---- stage 4: chroma difference and weighting denominators ----
	logic [15:0]         dcm;
	logic [27:0]         k1c1, k2c1;
	cie94_pkg::weights_t mode_a;

	always_comb begin
		mode_a = cie94_pkg::weights_t'(side2_a[15]);
		dcm    = (c1 >= c2) ? (c1 - c2) : (c2 - c1);
		k1c1   = ((mode_a == cie94_pkg::WEIGHTS_TEXTILE) ? cie94_pkg::K1_TEXTILE
		                                                  : cie94_pkg::K1_GRAPHIC) * c1;
		k2c1   = ((mode_a == cie94_pkg::WEIGHTS_TEXTILE) ? cie94_pkg::K2_TEXTILE
		                                                  : cie94_pkg::K2_GRAPHIC) * c1;
	end

	logic                vld_s4;
	logic [15:0]         dc_s4;
	logic [31:0]         dc2_s4;
	logic [32:0]         ab2_s4;
	logic [SDW-1:0]      sc_s4, sh_s4;
	logic [14:0]         dl_s4;
	cie94_pkg::weights_t mode_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= c1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s4   <= dcm;
			dc2_s4  <= dcm * dcm;
			ab2_s4  <= ab2_a;
			sc_s4   <= ONE + SDW'(k1c1);
			sh_s4   <= ONE + SDW'(k2c1);
			dl_s4   <= side2_a[14:0];
			mode_s4 <= mode_a;
		end
	end

	// ---- stage 5: hue term, clamp rounding noise at zero ----
	logic                vld_s5;
	logic [32:0]         dh2_s5;
	logic [SDW-1:0]      sc_s5, sh_s5;
	logic [15:0]         dc_s5;
	logic [14:0]         dl_s5;
	cie94_pkg::weights_t mode_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dh2_s5  <= (ab2_s4 > 33'(dc2_s4)) ? (ab2_s4 - 33'(dc2_s4)) : '0;
			sc_s5   <= sc_s4;
			sh_s5   <= sh_s4;
			dc_s5   <= dc_s4;
			dl_s5   <= dl_s4;
			mode_s5 <= mode_s4;
		end
	end

	// ---- hue root with guard bits ----
	logic           dh_vld;
	logic [24:0]    dh;
	logic [BSW-1:0] side_b;
	logic [49:0]    dh_rad;

	assign dh_rad = 50'({dh2_s5, {(2 * G){1'b0}}});

	cie94_sqrt_chain #(.RW(25), .SW(BSW)) u_hue_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s5),
		.rad_i  (dh_rad),
		.side_i ({sc_s5, sh_s5, dc_s5, dl_s5, mode_s5}),
		.vld_o  (dh_vld),
		.root_o (dh),
		.side_o (side_b)
	);

	// ---- chroma and hue divisions ----
	logic [SDW-1:0] sc_b, sh_b;
	logic [15:0]    dc_b;
	logic [14:0]    dl_b;
	logic           mode_b;
	logic [NW-1:0]  num_c, num_h;

	always_comb begin
		{sc_b, sh_b, dc_b, dl_b, mode_b} = side_b;
		num_c = NW'(dc_b) << (F + KS + G);
		num_h = NW'(dh) << (F + KS);
	end

	logic        rc_vld;
	logic [24:0] rc, rh;
	logic        mode_c;
	logic [14:0] dl_c;

	cie94_div_chain #(.DW(SDW), .QW(QW), .SW(1)) u_chroma_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (dh_vld),
		.hi_i   (SDW'(num_c[NW-1:QW])),
		.lo_i   (num_c[QW-1:0]),
		.dvs_i  (sc_b),
		.side_i (mode_b),
		.vld_o  (rc_vld),
		.quo_o  (rc),
		.side_o (mode_c)
	);

	cie94_div_chain #(.DW(SDW), .QW(QW), .SW(15)) u_hue_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (dh_vld),
		.hi_i   (SDW'(num_h[NW-1:QW])),
		.lo_i   (num_h[QW-1:0]),
		.dvs_i  (sh_b),
		.side_i (dl_b),
		.vld_o  (),
		.quo_o  (rh),
		.side_o (dl_c)
	);

	// ---- stage 7: squares of the weighted terms ----
	logic [22:0] rl;

	assign rl = (cie94_pkg::weights_t'(mode_c) == cie94_pkg::WEIGHTS_TEXTILE)
	          ? {1'b0, dl_c, 7'b0} : {dl_c, 8'b0};

	logic        vld_s7;
	logic [45:0] rl2_s7;
	logic [49:0] rc2_s7, rh2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= rc_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rl2_s7 <= rl * rl;
			rc2_s7 <= rc * rc;
			rh2_s7 <= rh * rh;
		end
	end

	// ---- stage 8: sum of squares ----
	logic        vld_s8;
	logic [51:0] sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8 <= 52'(rl2_s7) + 52'(rc2_s7) + 52'(rh2_s7);
		end
	end

	// ---- final root ----
	logic        de_vld;
	logic [25:0] de_root;
	logic        de_tag;

	cie94_sqrt_chain #(.RW(26), .SW(1)) u_final_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s8),
		.rad_i  (sum_s8),
		.side_i (vld_s8),
		.vld_o  (de_vld),
		.root_o (de_root),
		.side_o (de_tag)
	);

	// ---- stage 9: drop guard bits with rounding, clip at the top ----
	logic [26:0] rnd;
	logic [18:0] dq;

	always_comb begin
		rnd = 27'(de_root) + 27'(1 << (G - 1));
		dq  = 19'(rnd >> G);
	end

	logic                         vld_s9;
	logic [cie94_pkg::DIFF_W-1:0] diff_s9;
	logic                         sat_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= de_vld && de_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dq > 19'(cie94_pkg::DIFF_MAX)) begin
				diff_s9 <= cie94_pkg::DIFF_MAX;
				sat_s9  <= 1'b1;
			end else begin
				diff_s9 <= dq[cie94_pkg::DIFF_W-1:0];
				sat_s9  <= 1'b0;
			end
		end
	end

	// ---- output register and skid ----
	logic                         out_vld_q;
	logic [cie94_pkg::DIFF_W-1:0] out_diff_q, skid_diff_q;
	logic                         out_sat_q, skid_sat_q;
	logic                         deliver;
	logic                         out_free;

	assign deliver  = en && vld_s9;
	assign out_free = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// take from the skid first, else straight from the pipeline
			out_vld_q  <= skid_vld_q || deliver;
			skid_vld_q <= 1'b0;
		end else if (deliver) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_diff_q <= skid_diff_q;
				out_sat_q  <= skid_sat_q;
			end else begin
				out_diff_q <= diff_s9;
				out_sat_q  <= sat_s9;
			end
		end else if (deliver) begin
			skid_diff_q <= diff_s9;
			skid_sat_q  <= sat_s9;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.difference = out_diff_q;
	assign rsp.saturated  = out_sat_q;
endmodule

FILE: rtl/core/cie94_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cie94_sqrt_cell
// One digit of a restoring square root; registers the partial result.
// ----------------------------------------------------------------------------
module cie94_sqrt_cell #(
	parameter int RW = 16,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [2*RW-1:0] rad_o,
	output logic [RW+1:0]   rem_o,
	output logic [RW-1:0]   root_o,
	output logic [SW-1:0]   side_o
);
	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;

	always_comb begin
		cur   = {rem_i, rad_i[2*RW-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= ge ? diff[RW+1:0] : cur[RW+1:0];
			root_o <= {root_i[RW-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule

FILE: rtl/core/cie94_sqrt_chain.sv
// ----------------------------------------------------------------------------
// cie94_sqrt_chain
// Row of square root cells, one result bit per cell, floor root.
// ----------------------------------------------------------------------------
module cie94_sqrt_chain #(
	parameter int RW = 16,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RW-1:0] rad_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [RW-1:0]   root_o,
	output logic [SW-1:0]   side_o
);
	logic            vld  [0:RW];
	logic [2*RW-1:0] rad  [0:RW];
	logic [RW+1:0]   rem  [0:RW];
	logic [RW-1:0]   root [0:RW];
	logic [SW-1:0]   side [0:RW];

	assign vld[0]  = vld_i;
	assign rad[0]  = rad_i;
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign side[0] = side_i;

	for (genvar i = 0; i < RW; i++) begin : g_cell
		cie94_sqrt_cell #(.RW(RW), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld[i]),
			.rad_i  (rad[i]),
			.rem_i  (rem[i]),
			.root_i (root[i]),
			.side_i (side[i]),
			.vld_o  (vld[i+1]),
			.rad_o  (rad[i+1]),
			.rem_o  (rem[i+1]),
			.root_o (root[i+1]),
			.side_o (side[i+1])
		);
	end

	assign vld_o  = vld[RW];
	assign root_o = root[RW];
	assign side_o = side[RW];
endmodule

FILE: rtl/core/cie94_div_cell.sv
// ----------------------------------------------------------------------------
// cie94_div_cell
// One quotient bit of a restoring divider; registers the partial result.
// ----------------------------------------------------------------------------
module cie94_div_cell #(
	parameter int DW = 29,
	parameter int QW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] num_i,
	input  logic [QW-1:0] quo_i,
	input  logic [DW-1:0] dvs_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] num_o,
	output logic [QW-1:0] quo_o,
	output logic [DW-1:0] dvs_o,
	output logic [SW-1:0] side_o
);
	logic [DW:0] cur;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		cur  = {rem_i, num_i[QW-1]};
		diff = cur - {1'b0, dvs_i};
		ge   = (cur >= {1'b0, dvs_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[DW-1:0] : cur[DW-1:0];
			num_o  <= num_i << 1;
			quo_o  <= {quo_i[QW-2:0], ge};
			dvs_o  <= dvs_i;
			side_o <= side_i;
		end
	end
endmodule

FILE: rtl/core/cie94_div_chain.sv
// ----------------------------------------------------------------------------
// cie94_div_chain
// Row of divider cells, one quotient bit per cell, floor quotient.
// The upper dividend part must already be below the divisor.
// ----------------------------------------------------------------------------
module cie94_div_chain #(
	parameter int DW = 29,
	parameter int QW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] hi_i,
	input  logic [QW-1:0] lo_i,
	input  logic [DW-1:0] dvs_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);
	logic          vld  [0:QW];
	logic [DW-1:0] rem  [0:QW];
	logic [QW-1:0] num  [0:QW];
	logic [QW-1:0] quo  [0:QW];
	logic [DW-1:0] dvs  [0:QW];
	logic [SW-1:0] side [0:QW];

	assign vld[0]  = vld_i;
	assign rem[0]  = hi_i;
	assign num[0]  = lo_i;
	assign quo[0]  = '0;
	assign dvs[0]  = dvs_i;
	assign side[0] = side_i;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		cie94_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld[i]),
			.rem_i  (rem[i]),
			.num_i  (num[i]),
			.quo_i  (quo[i]),
			.dvs_i  (dvs[i]),
			.side_i (side[i]),
			.vld_o  (vld[i+1]),
			.rem_o  (rem[i+1]),
			.num_o  (num[i+1]),
			.quo_o  (quo[i+1]),
			.dvs_o  (dvs[i+1]),
			.side_o (side[i+1])
		);
	end

	assign vld_o  = vld[QW];
	assign quo_o  = quo[QW];
	assign side_o = side[QW];
endmodule

FILE: sim/cie94_color_difference_core_tb.sv
// ----------------------------------------------------------------------------
// cie94_color_difference_core_tb
// Self-checking bench for the CIE94 delta E core. Color pairs go in through
// the request channel in random bursts. A bit-exact fixed-point model of the
// difference predicts each result beat. The result channel stalls on its own
// pattern, and the weight select is switched between drained phases.
// ----------------------------------------------------------------------------
module cie94_color_difference_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS  = 8;
	// request-to-result latency plus margin, used for drains
	localparam int PIPE_DEPTH = 110;

	typedef struct packed {
		logic [cie94_pkg::LIGHT_W-1:0]       l1;
		logic signed [cie94_pkg::AXIS_W-1:0] a1;
		logic signed [cie94_pkg::AXIS_W-1:0] b1;
		logic [cie94_pkg::LIGHT_W-1:0]       l2;
		logic signed [cie94_pkg::AXIS_W-1:0] a2;
		logic signed [cie94_pkg::AXIS_W-1:0] b2;
	} lab_pair_t;

	typedef struct packed {
		logic [cie94_pkg::DIFF_W-1:0] difference;
		logic                         saturated;
	} delta_e_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	cie94_in_if  req ();
	cie94_out_if rsp ();

	cie94_color_difference_core #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	cie94_pkg::weights_t weights_sel;
	delta_e_t            pending_deltas[$];
	int                  errors;
	int                  rx_mode;
	bit                  rx_hold;
	int                  rx_count;
	int                  burst_left;

	// ------------------------------------------------------------------------
	// Clock, reset and run limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Delta E model
	// ------------------------------------------------------------------------
	// Bit-serial floor square root over 64 bits.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned abs64(longint x);
		return (x < 0) ? longint'(-x) : longint'(x);
	endfunction

	function automatic delta_e_t cie94_delta(lab_pair_t p, cie94_pkg::weights_t w);
		longint unsigned k1, k2, c1, c2, dl, dc, da, db, ab2, dc2, dh2, dh;
		longint unsigned unity, sc, sh, rl, rc, rh, sum, d;
		delta_e_t r;
		k1 = 64'((w == cie94_pkg::WEIGHTS_TEXTILE) ? cie94_pkg::K1_TEXTILE
			: cie94_pkg::K1_GRAPHIC);
		k2 = 64'((w == cie94_pkg::WEIGHTS_TEXTILE) ? cie94_pkg::K2_TEXTILE
			: cie94_pkg::K2_GRAPHIC);
		c1 = floor_root(abs64(p.a1) * abs64(p.a1) + abs64(p.b1) * abs64(p.b1));
		c2 = floor_root(abs64(p.a2) * abs64(p.a2) + abs64(p.b2) * abs64(p.b2));
		dl = abs64(longint'(p.l1) - longint'(p.l2));
		dc = abs64(longint'(c1) - longint'(c2));
		da = abs64(longint'(p.a1) - longint'(p.a2));
		db = abs64(longint'(p.b1) - longint'(p.b2));
		ab2 = da * da + db * db;
		dc2 = dc * dc;
		// rounding in the roots can push the hue term below zero: clamp it
		dh2 = (ab2 > dc2) ? ab2 - dc2 : 64'd0;
		dh = floor_root(dh2 << (2 * cie94_pkg::GUARD_BITS));
		unity = 64'd1 << (FRAC_BITS + cie94_pkg::K_SCALE_BITS);
		sc = unity + k1 * c1;
		sh = unity + k2 * c1;
		rl = (w == cie94_pkg::WEIGHTS_TEXTILE) ? dl << (cie94_pkg::GUARD_BITS - 1)
			: dl << cie94_pkg::GUARD_BITS;
		rc = (dc << (FRAC_BITS + cie94_pkg::K_SCALE_BITS + cie94_pkg::GUARD_BITS)) / sc;
		rh = (dh << (FRAC_BITS + cie94_pkg::K_SCALE_BITS)) / sh;
		sum = rl * rl + rc * rc + rh * rh;
		d = (floor_root(sum) + (64'd1 << (cie94_pkg::GUARD_BITS - 1)))
			>> cie94_pkg::GUARD_BITS;
		r.saturated = 1'b0;
		if (d > 64'(cie94_pkg::DIFF_MAX)) begin
			d = 64'(cie94_pkg::DIFF_MAX);
			r.saturated = 1'b1;
		end
		r.difference = d[cie94_pkg::DIFF_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result receiver: stall pattern plus a forced long hold
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_count  <= 0;
			rx_mode   <= 0;
		end else begin
			rx_count <= rx_count + 1;
			// periodically pick a new random stall style
			if (rx_count % 64 == 63)
				rx_mode <= int'($urandom_range(0, 3));
			if (rx_hold)
				rsp.ready <= 1'b0;
			else case (rx_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 9) > 2);
				2: rsp.ready <= (rx_count % 5 != 0);
				default: rsp.ready <= ($urandom_range(0, 9) > 7);
			endcase
		end
	end

	// Compare each result beat against the oldest prediction.
	always @(posedge clk) begin
		delta_e_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_deltas.size() == 0) begin
				$error("unexpected result beat: difference %0d", rsp.difference);
				errors++;
			end else begin
				want = pending_deltas.pop_front();
				if (rsp.difference !== want.difference) begin
					$error("difference: expected %0d, got %0d",
						want.difference, rsp.difference);
					errors++;
				end
				if (rsp.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b",
						want.saturated, rsp.saturated);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------------
	// Offer one pair, hold it until the beat is taken, then maybe gap.
	task automatic send_pair(lab_pair_t p, bit bursty = 1'b1);
		int gap;
		req.valid              <= 1'b1;
		req.light_first        <= p.l1;
		req.green_red_first    <= p.a1;
		req.blue_yellow_first  <= p.b1;
		req.light_second       <= p.l2;
		req.green_red_second   <= p.a2;
		req.blue_yellow_second <= p.b2;
		do @(posedge clk); while (!req.ready);
		pending_deltas.push_back(cie94_delta(p, weights_sel));
		if (!bursty)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_deltas.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_weights(cie94_pkg::weights_t w);
		cfg_we      <= 1'b1;
		cfg_wdata   <= w;
		@(posedge clk);
		cfg_we      <= 1'b0;
		weights_sel = w;
	endtask

	function automatic lab_pair_t make_pair(int l1, int a1, int b1,
		int l2, int a2, int b2);
		lab_pair_t p;
		p.l1 = 15'(l1); p.a1 = 16'(a1); p.b1 = 16'(b1);
		p.l2 = 15'(l2); p.a2 = 16'(a2); p.b2 = 16'(b2);
		return p;
	endfunction

	function automatic logic signed [cie94_pkg::AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($signed($urandom_range(0, 4000)) - 2000);
			2: return 16'($signed($urandom_range(0, 30000)) - 15000);
			default: return $urandom_range(0, 1)
				? 16'(16'sh7FFF - $urandom_range(0, 15))
				: 16'(16'sh8000 + $urandom_range(0, 15));
		endcase
	endfunction

	function automatic lab_pair_t rand_pair();
		lab_pair_t p;
		// lightness mostly in 0..100, sometimes anywhere in the field
		p.l1 = 15'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(0, 25600));
		p.l2 = 15'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(0, 25600));
		p.a1 = rand_axis();
		p.b1 = rand_axis();
		if ($urandom_range(0, 2) == 0) begin
			// close colors: the hue term sits near zero and may round negative
			p.a2 = 16'(p.a1 + $signed($urandom_range(0, 6)) - 3);
			p.b2 = 16'(p.b1 + $signed($urandom_range(0, 6)) - 3);
			p.l2 = p.l1 ^ 15'($urandom_range(0, 3));
		end else begin
			p.a2 = rand_axis();
			p.b2 = rand_axis();
		end
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Field extremes, identical colors and hue clamp corners.
	task automatic test_directed();
		send_pair(make_pair(0, 0, 0, 0, 0, 0), 1'b0);
		send_pair(make_pair(32767, 0, 0, 0, 0, 0), 1'b0);
		send_pair(make_pair(25600, 0, 0, 0, 0, 0), 1'b0);
		send_pair(make_pair(0, -32768, -32768, 32767, 32767, 32767), 1'b0);
		send_pair(make_pair(32767, 32767, 32767, 0, -32768, -32768), 1'b0);
		send_pair(make_pair(12800, -32768, 0, 12800, 32767, 0), 1'b0);
		send_pair(make_pair(12800, 0, -32768, 12800, 0, 32767), 1'b0);
		send_pair(make_pair(5000, 1234, -4321, 5000, 1234, -4321), 1'b0);
		send_pair(make_pair(5000, 300, 400, 5000, 301, 399), 1'b0);
		send_pair(make_pair(5000, 3, 4, 5000, 4, 3), 1'b0);
		send_pair(make_pair(100, 1, 1, 100, 1, 0), 1'b0);
		send_pair(make_pair(0, 10000, 0, 0, 20000, 0), 1'b0);
		send_pair(make_pair(0, 0, 10000, 0, 0, -10000), 1'b0);
		send_pair(make_pair(25600, -32768, -32768, 25600, -32767, -32768), 1'b0);
		send_pair(make_pair(1, 21845, -10922, 0, -21846, 10921), 1'b0);
		send_pair(make_pair(32767, -1, -1, 32766, 1, 1), 1'b0);
		drain_results();
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_pair(rand_pair());
		drain_results();
	endtask

	// Hold results off long enough that the pipe fills and req.ready drops.
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			repeat (160)
				send_pair(rand_pair(), 1'b0);
		join
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		errors      = 0;
		rx_hold     = 1'b0;
		burst_left  = 0;
		weights_sel = cie94_pkg::WEIGHTS_GRAPHIC;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		req.valid              = 1'b0;
		req.light_first        = '0;
		req.green_red_first    = '0;
		req.blue_yellow_first  = '0;
		req.light_second       = '0;
		req.green_red_second   = '0;
		req.blue_yellow_second = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value is graphic arts; run directed once with it untouched
		test_directed();
		write_weights(cie94_pkg::WEIGHTS_TEXTILE);
		test_directed();
		test_random(150);
		write_weights(cie94_pkg::WEIGHTS_GRAPHIC);
		test_random(150);
		test_backpressure();
		write_weights(cie94_pkg::WEIGHTS_TEXTILE);
		test_random(150);
		write_weights(cie94_pkg::WEIGHTS_GRAPHIC);
		test_random(20);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
